// ===== rtl/percentile_band_selector_core_macros.svh =====
// ----------------------------------------------------------------------------
// Percentile band selector: assertion macros
// Shared concurrent assertion forms, clocked and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PERCENTILE_BAND_SELECTOR_CORE_MACROS_SVH
`define PERCENTILE_BAND_SELECTOR_CORE_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define PBS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Percentile band selector: package
// Widths, constants and beat types shared by the sorter cells, the divider
// and the top level.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int unsigned MAX_SAMPLES = 1024;
    localparam int unsigned IDX_W       = $clog2(MAX_SAMPLES);
    localparam int unsigned CNT_W       = $clog2(MAX_SAMPLES + 1);

    localparam int unsigned DATA_W      = 32;
    localparam int unsigned LEVEL_W     = 14;
    localparam int unsigned LEVEL_MAX   = 10000;
    localparam int unsigned LEVEL_DEN   = 20000;
    localparam int unsigned NUM_W       = 15;
    localparam int unsigned REM_W       = 15;
    localparam int unsigned QUO_W       = 32;
    localparam int unsigned DIVD_W      = QUO_W + REM_W;
    localparam int unsigned CHUNK_W     = 16;
    localparam int unsigned NUM_CHUNKS  = QUO_W / CHUNK_W;
    localparam int unsigned CHUNK_CNT_W = $clog2(NUM_CHUNKS + 1);
    localparam int unsigned PART_W      = REM_W + CHUNK_W;
    localparam int unsigned RECIP_W     = 32;
    localparam int unsigned RECIP_SH    = PART_W + REM_W;
    localparam int unsigned PROD_W      = PART_W + RECIP_W;
    localparam int unsigned NUM_Q       = 4;
    localparam int unsigned Q_W         = $clog2(NUM_Q);

    // Rounded-up reciprocal of the denominator, scaled by 2^RECIP_SH.
    localparam logic [RECIP_W-1:0] DEN_RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(LEVEL_DEN) - 64'd1) / 64'(LEVEL_DEN));

    localparam int unsigned CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 1'b1;

    localparam logic [LEVEL_W-1:0] OUTER_RESET = LEVEL_W'(9000);
    localparam logic [LEVEL_W-1:0] INNER_RESET = LEVEL_W'(6800);

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     last_sample;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] upper_outer;
        logic signed [DATA_W-1:0] lower_outer;
        logic signed [DATA_W-1:0] upper_inner;
        logic signed [DATA_W-1:0] lower_inner;
        logic                     set_empty;
        logic                     set_overflowed;
    } t_out_beat;

    typedef struct packed {
        logic                     ins;
        logic                     shift;
        logic signed [DATA_W-1:0] sample;
    } t_cell_ctrl;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
        logic [REM_W-1:0] remainder;
    } t_div_rsp;

endpackage

// ===== rtl/pbs_cell.sv =====
// ----------------------------------------------------------------------------
// Percentile band selector: sorter cell
// One slot of the ascending insertion chain. It keeps its value, takes the
// new sample or its left neighbour's value on an insert, and takes its right
// neighbour's value while the chain drains.
// ----------------------------------------------------------------------------
module pbs_cell
    import pbs_pkg::*;
(
    input  logic                     i_clk,
    input  t_cell_ctrl               i_ctrl,
    input  logic                     i_occ,
    input  logic signed [DATA_W-1:0] i_left_val,
    input  logic                     i_left_le,
    input  logic signed [DATA_W-1:0] i_right_val,
    output logic signed [DATA_W-1:0] o_val,
    output logic                     o_le
);

    logic signed [DATA_W-1:0] r_val;
    logic signed [DATA_W-1:0] n_val;

    assign o_le  = i_occ && (r_val <= i_ctrl.sample);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.shift) begin
            n_val = i_right_val;
        end else if (i_ctrl.ins && !o_le) begin
            n_val = i_left_le ? i_ctrl.sample : i_left_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== rtl/pbs_div.sv =====
// ----------------------------------------------------------------------------
// Percentile band selector: divider
// Division by the level denominator, one 16-bit quotient digit at a time:
// a multiply step, then a remainder step. Each digit comes from a
// multiplication by the rounded-up reciprocal, which is exact for a
// partial dividend below 2^31, and the remainder follows from it. The
// upper part of the dividend must be below the denominator.
// ----------------------------------------------------------------------------
module pbs_div
    import pbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                   r_busy;
    logic                   r_phase;
    logic [CHUNK_CNT_W-1:0] r_cnt;
    logic [REM_W-1:0]       r_rem;
    logic [QUO_W-1:0]       r_sh;
    logic [PROD_W-1:0]      r_prod;
    logic [PART_W-1:0]      part;
    logic [CHUNK_W-1:0]     digit;
    logic [PART_W-1:0]      back;

    assign part  = {r_rem, r_sh[QUO_W-1 -: CHUNK_W]};
    assign digit = r_prod[RECIP_SH +: CHUNK_W];
    assign back  = PART_W'(digit) * PART_W'(LEVEL_DEN);

    assign o_rsp.done      = r_busy && (r_cnt == '0);
    assign o_rsp.quotient  = r_sh;
    assign o_rsp.remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
                r_cnt   <= CHUNK_CNT_W'(NUM_CHUNKS);
                r_rem   <= i_req.dividend[DIVD_W-1:QUO_W];
                r_sh    <= i_req.dividend[QUO_W-1:0];
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else if (!r_phase) begin
                    r_prod  <= PROD_W'(part) * PROD_W'(DEN_RECIP);
                    r_phase <= 1'b1;
                end else begin
                    r_rem   <= REM_W'(part - back);
                    r_sh    <= {r_sh[QUO_W-CHUNK_W-1:0], digit};
                    r_cnt   <= r_cnt - CHUNK_CNT_W'(1);
                    r_phase <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== rtl/percentile_band_selector_core.sv =====
// ----------------------------------------------------------------------------
// Percentile band selector: top level
// Sorts incoming samples in a chain of cells and, on the last beat of a set,
// gives four linearly interpolated percentiles for the outer and inner bands.
//
//   Channel   Direction  Handshake               Payload
//   in        sink       i_in_valid/o_in_stall   i_in_data  (t_in_beat)
//   out       source     o_out_valid/i_out_stall o_out_data (t_out_beat)
//   cfg       sink       i_cfg_we                i_cfg_idx, i_cfg_wdata
//
// Sample beats are accepted back to back while loading; the chain inserts
// each in place. After the last beat of a non-empty set the input stalls
// while four divisions place the positions, one drain walks the n cells,
// up to four divisions interpolate and the result goes to the output
// register once it is free. The result waits in that output register, and
// loading of the next set carries on while it is held. The cells are not
// cleared at reset; only the state, the fill count, the flags and the
// levels are reset.
// ----------------------------------------------------------------------------
`include "percentile_band_selector_core_macros.svh"

module percentile_band_selector_core
    import pbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEVEL_W-1:0]   i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PMUL,
        S_PDIV,
        S_DRAIN,
        S_IMUL,
        S_IDIV,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [LEVEL_W-1:0]       r_outer_lvl;
    logic [LEVEL_W-1:0]       r_inner_lvl;
    logic [CNT_W-1:0]         r_count;
    logic                     r_ovf;
    logic [CNT_W-1:0]         r_n;
    logic                     r_set_ovf;
    logic [Q_W-1:0]           r_q;
    logic [IDX_W-1:0]         r_k;
    logic [DIVD_W-1:0]        r_prod;
    logic                     r_div_start;
    logic                     r_out_valid;
    t_out_beat                r_out_data;
    logic [NUM_W-1:0]         r_num   [NUM_Q];
    logic [IDX_W-1:0]         r_lo    [NUM_Q];
    logic [REM_W-1:0]         r_frac  [NUM_Q];
    logic signed [DATA_W-1:0] r_lov   [NUM_Q];
    logic signed [DATA_W-1:0] r_hiv   [NUM_Q];
    logic signed [DATA_W-1:0] r_res   [NUM_Q];

    logic                     in_acc;
    logic                     full;
    logic [IDX_W-1:0]         nm1;
    logic [NUM_W-1:0]         lv_o;
    logic [NUM_W-1:0]         lv_i;
    logic [DATA_W-1:0]        diff;
    logic [DATA_W-1:0]        mult_a;
    logic [REM_W-1:0]         mult_b;
    logic [DIVD_W-1:0]        mult_p;
    t_cell_ctrl               cell_ctrl;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;
    logic signed [DATA_W-1:0] cell_val [MAX_SAMPLES];
    logic                     cell_le  [MAX_SAMPLES];

    assign o_in_stall  = (r_state != S_LOAD);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign full        = (r_count == CNT_W'(MAX_SAMPLES));
    assign nm1         = IDX_W'(r_n - CNT_W'(1));
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign lv_o = (r_outer_lvl > LEVEL_W'(LEVEL_MAX)) ? NUM_W'(LEVEL_MAX) : NUM_W'(r_outer_lvl);
    assign lv_i = (r_inner_lvl > LEVEL_W'(LEVEL_MAX)) ? NUM_W'(LEVEL_MAX) : NUM_W'(r_inner_lvl);

    assign diff   = r_hiv[r_q] - r_lov[r_q];
    assign mult_a = (r_state == S_PMUL) ? DATA_W'(nm1) : diff;
    assign mult_b = (r_state == S_PMUL) ? r_num[r_q] : r_frac[r_q];
    assign mult_p = DIVD_W'(mult_a) * DIVD_W'(mult_b);

    assign cell_ctrl.ins    = in_acc && !full;
    assign cell_ctrl.shift  = (r_state == S_DRAIN);
    assign cell_ctrl.sample = i_in_data.sample;

    assign div_req.start    = r_div_start;
    assign div_req.dividend = r_prod;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
            logic signed [DATA_W-1:0] left_val;
            logic                     left_le;
            logic signed [DATA_W-1:0] right_val;
            logic                     occ;

            if (gi == 0) begin : g_head
                assign left_val = '0;
                assign left_le  = 1'b1;
            end else begin : g_body
                assign left_val = cell_val[gi-1];
                assign left_le  = cell_le[gi-1];
            end

            if (gi == MAX_SAMPLES - 1) begin : g_tail
                assign right_val = '0;
            end else begin : g_next
                assign right_val = cell_val[gi+1];
            end

            assign occ = CNT_W'(gi) < r_count;

            pbs_cell u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (cell_ctrl),
                .i_occ       (occ),
                .i_left_val  (left_val),
                .i_left_le   (left_le),
                .i_right_val (right_val),
                .o_val       (cell_val[gi]),
                .o_le        (cell_le[gi])
            );
        end
    endgenerate

    pbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_outer_lvl <= OUTER_RESET;
            r_inner_lvl <= INNER_RESET;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_div_start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OUTER: begin
                        r_outer_lvl <= i_cfg_wdata;
                    end
                    CFG_INNER: begin
                        r_inner_lvl <= i_cfg_wdata;
                    end
                endcase
            end

            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (full) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_in_data.last_sample) begin
                            r_n       <= full ? r_count : r_count + CNT_W'(1);
                            r_set_ovf <= r_ovf | full;
                            r_num[0]  <= NUM_W'(LEVEL_MAX) + lv_o;
                            r_num[1]  <= NUM_W'(LEVEL_MAX) - lv_o;
                            r_num[2]  <= NUM_W'(LEVEL_MAX) + lv_i;
                            r_num[3]  <= NUM_W'(LEVEL_MAX) - lv_i;
                            r_q       <= '0;
                            r_state   <= S_PMUL;
                        end
                    end
                end
                S_PMUL: begin
                    if (r_n == '0) begin
                        for (int j = 0; j < NUM_Q; j++) begin
                            r_res[j] <= '0;
                        end
                        r_ovf   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_prod      <= mult_p;
                        r_div_start <= 1'b1;
                        r_state     <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    r_div_start <= 1'b0;
                    if (div_rsp.done) begin
                        r_lo[r_q]   <= div_rsp.quotient[IDX_W-1:0];
                        r_frac[r_q] <= div_rsp.remainder;
                        if (r_q == Q_W'(NUM_Q - 1)) begin
                            r_k     <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_q     <= r_q + Q_W'(1);
                            r_state <= S_PMUL;
                        end
                    end
                end
                S_DRAIN: begin
                    for (int j = 0; j < NUM_Q; j++) begin
                        if (r_k == r_lo[j]) begin
                            r_lov[j] <= cell_val[0];
                        end
                        if (CNT_W'(r_k) == CNT_W'(r_lo[j]) + CNT_W'(1)) begin
                            r_hiv[j] <= cell_val[0];
                        end
                    end
                    if (r_k == nm1) begin
                        r_q     <= '0;
                        r_count <= '0;
                        r_ovf   <= 1'b0;
                        r_state <= S_IMUL;
                    end else begin
                        r_k <= r_k + IDX_W'(1);
                    end
                end
                S_IMUL: begin
                    if (r_frac[r_q] == '0) begin
                        r_res[r_q] <= r_lov[r_q];
                        if (r_q == Q_W'(NUM_Q - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_q <= r_q + Q_W'(1);
                        end
                    end else begin
                        r_prod      <= mult_p + DIVD_W'(LEVEL_DEN / 2);
                        r_div_start <= 1'b1;
                        r_state     <= S_IDIV;
                    end
                end
                S_IDIV: begin
                    r_div_start <= 1'b0;
                    if (div_rsp.done) begin
                        r_res[r_q] <= r_lov[r_q] + $signed(div_rsp.quotient);
                        if (r_q == Q_W'(NUM_Q - 1)) begin
                            r_state <= S_DONE;
                        end else begin
                            r_q     <= r_q + Q_W'(1);
                            r_state <= S_IMUL;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_data.upper_outer    <= r_res[0];
                        r_out_data.lower_outer    <= r_res[1];
                        r_out_data.upper_inner    <= r_res[2];
                        r_out_data.lower_inner    <= r_res[3];
                        r_out_data.set_empty      <= (r_n == '0);
                        r_out_data.set_overflowed <= r_set_ovf;
                        r_out_valid               <= 1'b1;
                        r_state                   <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    `PBS_ASSERT_NEXT(a_last_stalls, i_clk, i_rst_n, in_acc && i_in_data.last_sample, o_in_stall, "last beat did not stall the input")
    `PBS_ASSERT_SAME(a_div_done_state, i_clk, i_rst_n, div_rsp.done, (r_state == S_PDIV) || (r_state == S_IDIV), "divider finished outside a division step")
    `PBS_ASSERT_SAME(a_drain_bound, i_clk, i_rst_n, r_state == S_DRAIN, CNT_W'(r_k) < r_n, "drain ran past the set size")

endmodule

// ===== tb/percentile_band_selector_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Percentile band selector: self-checking testbench
// Sample beats are queued by a stimulus process and presented by a clocked
// driver. A clocked monitor keeps its own sorted copy of each set and works
// out the four interpolated percentiles when the last beat of a set is
// accepted. It compares every result beat, field by field, with the oldest
// predicted band. A directed part covers the extreme samples and levels,
// unsorted and repeated values, exact and half-way positions, and levels
// above range. Random sets follow under several level settings, one of them
// large enough to overflow the store. The output side holds off once for a
// long stretch, so that the block fills up and stalls its input.
// ----------------------------------------------------------------------------
module percentile_band_selector_core_test;
    import pbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = MAX_SAMPLES + 300;
    localparam int RANDOM_BEATS   = 1780;
    localparam int HOLD_CYCLES    = 1500;
    localparam int HOLD_AT_BAND   = 12;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_beat             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_beat            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_OUTER;
    logic [LEVEL_W-1:0]   i_cfg_wdata = '0;

    t_in_beat     pending_beats[$];
    t_out_beat    band_q[$];
    int           sorted_samples[$];
    bit           overflow_seen = 1'b0;
    int unsigned  outer_lv = OUTER_RESET;
    int unsigned  inner_lv = INNER_RESET;

    bit           drv_idle_on = 1'b1;
    bit           rcv_idle_on = 1'b1;
    int           drv_gap = 0;
    int           rcv_gap = 0;
    int           hold_cnt = 0;
    bit           hold_done = 1'b0;
    int           bands_seen = 0;
    int           samples_seen = 0;
    int           mismatches = 0;
    int           quiet = 0;
    int           level_settings = 1;

    percentile_band_selector_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic signed [DATA_W-1:0] percentile_at(int unsigned num);
        int unsigned       n;
        longint unsigned   pos;
        int unsigned       lo;
        int unsigned       rem;
        longint            lov;
        longint            diff;
        longint unsigned   step;
        n    = sorted_samples.size();
        pos  = longint'(num) * longint'(n - 1);
        lo   = int'(pos / LEVEL_DEN);
        rem  = int'(pos % LEVEL_DEN);
        if (lo >= n) begin
            lo = n - 1;
        end
        lov = sorted_samples[lo];
        if (rem == 0 || lo + 1 >= n) begin
            return lov[DATA_W-1:0];
        end
        diff = longint'(sorted_samples[lo + 1]) - lov;
        step = (longint'(diff) * longint'(rem) + LEVEL_DEN / 2) / LEVEL_DEN;
        return DATA_W'(lov + longint'(step));
    endfunction

    function automatic int unsigned clamp_level(int unsigned lv);
        return (lv > LEVEL_MAX) ? LEVEL_MAX : lv;
    endfunction

    task automatic take_sample(t_in_beat b);
        t_out_beat   band;
        int          idx;
        int unsigned lvo;
        int unsigned lvi;
        if (sorted_samples.size() < MAX_SAMPLES) begin
            idx = sorted_samples.size();
            while (idx > 0 && sorted_samples[idx - 1] > b.sample) begin
                idx--;
            end
            sorted_samples.insert(idx, b.sample);
        end else begin
            overflow_seen = 1'b1;
        end
        if (b.last_sample) begin
            band = '0;
            lvo  = clamp_level(outer_lv);
            lvi  = clamp_level(inner_lv);
            if (sorted_samples.size() > 0) begin
                band.upper_outer = percentile_at(LEVEL_MAX + lvo);
                band.lower_outer = percentile_at(LEVEL_MAX - lvo);
                band.upper_inner = percentile_at(LEVEL_MAX + lvi);
                band.lower_inner = percentile_at(LEVEL_MAX - lvi);
            end
            band.set_empty      = (sorted_samples.size() == 0);
            band.set_overflowed = overflow_seen;
            band_q.push_back(band);
            sorted_samples.delete();
            overflow_seen = 1'b0;
        end
    endtask

    task automatic compare_field(string name, logic [DATA_W-1:0] want,
                                 logic [DATA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, actual %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (band_q.size() == 0) begin
                    $error("result beat with no band expected: %h", o_out_data);
                    mismatches++;
                end else begin
                    want = band_q.pop_front();
                    compare_field("upper_outer", want.upper_outer, o_out_data.upper_outer);
                    compare_field("lower_outer", want.lower_outer, o_out_data.lower_outer);
                    compare_field("upper_inner", want.upper_inner, o_out_data.upper_inner);
                    compare_field("lower_inner", want.lower_inner, o_out_data.lower_inner);
                    compare_field("set_empty", 32'(want.set_empty),
                                  32'(o_out_data.set_empty));
                    compare_field("set_overflowed", 32'(want.set_overflowed),
                                  32'(o_out_data.set_overflowed));
                end
                bands_seen <= bands_seen + 1;
            end
            if (i_in_valid && !o_in_stall) begin
                take_sample(i_in_data);
                samples_seen <= samples_seen + 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            drv_gap    <= 0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (drv_gap > 0) begin
                i_in_valid <= 1'b0;
                drv_gap    <= drv_gap - 1;
            end else if (pending_beats.size() > 0) begin
                i_in_data  <= pending_beats.pop_front();
                i_in_valid <= 1'b1;
                if (drv_idle_on && $urandom_range(0, 5) == 0) begin
                    drv_gap <= $urandom_range(1, 19);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rcv_gap     <= 0;
            hold_cnt    <= 0;
        end else if (hold_cnt > 0) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= hold_cnt - 1;
        end else if (!hold_done && bands_seen == HOLD_AT_BAND) begin
            i_out_stall <= 1'b1;
            hold_cnt    <= HOLD_CYCLES;
            hold_done   <= 1'b1;
        end else if (rcv_gap > 0) begin
            i_out_stall <= 1'b1;
            rcv_gap     <= rcv_gap - 1;
        end else if (rcv_idle_on && $urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            rcv_gap     <= $urandom_range(0, 18);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("percentile_band_selector_core verification failed");
            $finish;
        end
    end

    task automatic push_beat(int x, bit last);
        t_in_beat b;
        b.sample      = x;
        b.last_sample = last;
        pending_beats.push_back(b);
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || band_q.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_levels(int unsigned outer, int unsigned inner);
        wait_drained();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_OUTER;
        i_cfg_wdata <= LEVEL_W'(outer);
        outer_lv     = outer;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_INNER;
        i_cfg_wdata <= LEVEL_W'(inner);
        inner_lv     = inner;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        level_settings++;
    endtask

    task automatic queue_random_set(int n, int style);
        int base;
        int x;
        base = int'($urandom);
        for (int k = 0; k < n; k++) begin
            case (style)
                0: begin
                    x = int'($urandom);
                end
                1: begin
                    x = int'($urandom_range(0, 400)) - 200;
                end
                2: begin
                    x = base + int'($urandom_range(0, 3)) * 65536;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: x = 32'h8000_0000;
                        1: x = 32'h7FFF_FFFF;
                        2: x = 0;
                        default: x = -1;
                    endcase
                end
            endcase
            push_beat(x, k == n - 1);
        end
    endtask

    initial begin
        int rand_beats;
        int phase;
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_beat(32'h8000_0000, 1'b1);
        push_beat(32'h7FFF_FFFF, 1'b1);
        push_beat(32'h8000_0000, 1'b0);
        push_beat(32'h7FFF_FFFF, 1'b1);
        push_beat(5, 1'b0);
        push_beat(-3, 1'b0);
        push_beat(5, 1'b0);
        push_beat(0, 1'b1);

        set_levels(0, LEVEL_MAX);
        push_beat(100, 1'b0);
        push_beat(-100, 1'b0);
        push_beat(7, 1'b0);
        push_beat(65536, 1'b1);

        set_levels(16383, LEVEL_MAX + 1);
        push_beat(-65536, 1'b0);
        push_beat(65536, 1'b0);
        push_beat(3, 1'b1);

        set_levels(1, LEVEL_MAX - 1);
        push_beat(32'h7FFF_FFFF, 1'b0);
        push_beat(32'h8000_0000, 1'b0);
        push_beat(-1, 1'b0);
        push_beat(1, 1'b1);

        rand_beats = 0;
        phase      = 0;
        while (rand_beats < RANDOM_BEATS) begin
            case (phase)
                0: set_levels(OUTER_RESET, INNER_RESET);
                1: set_levels(LEVEL_MAX, 0);
                2: set_levels(0, 0);
                3: set_levels(16383, 16383);
                4: set_levels(5000, 2500);
                default: set_levels($urandom_range(0, 16383), $urandom_range(0, LEVEL_MAX));
            endcase
            for (int s = 0; s < 12 && rand_beats < RANDOM_BEATS; s++) begin
                while (pending_beats.size() > 8) begin
                    @(posedge i_clk);
                end
                if (phase == 2 && s == 0) begin
                    n = MAX_SAMPLES + 2;
                end else if ($urandom_range(0, 3) == 0) begin
                    n = $urandom_range(1, 4);
                end else begin
                    n = $urandom_range(1, 24);
                end
                if (rand_beats > RANDOM_BEATS - 300) begin
                    drv_idle_on = 1'b0;
                    rcv_idle_on = 1'b0;
                end else begin
                    drv_idle_on = ($urandom_range(0, 3) != 0);
                    rcv_idle_on = ($urandom_range(0, 3) != 0);
                end
                queue_random_set(n, (n > MAX_SAMPLES) ? 0 : $urandom_range(0, 3));
                rand_beats += n;
            end
            phase++;
        end

        wait_drained();
        $display("Run covered %0d sample beats and %0d band results under %0d level settings,",
                 samples_seen, bands_seen, level_settings);
        $display("including an overflowed set and a long output hold-off.");
        if (mismatches == 0) begin
            $display("percentile_band_selector_core verification clean");
        end else begin
            $display("percentile_band_selector_core verification failed");
        end
        $finish;
    end

endmodule
